[rtl/load_switch_i2t_protector_top_macros.svh]
// Assertion macros for the load switch protector.
// Included by the top level; no other dependencies.
`ifndef LOAD_SWITCH_I2T_PROTECTOR_TOP_MACROS_SVH
`define LOAD_SWITCH_I2T_PROTECTOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked at every rising edge outside reset.
`define LSP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication checked at every rising edge outside reset.
`define LSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define LSP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LSP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/lsp_pkg.sv]
// Shared types and constants for the load switch protector.
// No dependencies.
package lsp_pkg;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_MAX_VOLTAGE     = 3'd0;
   localparam logic [2:0] REG_MIN_VOLTAGE     = 3'd1;
   localparam logic [2:0] REG_NOMINAL_CURRENT = 3'd2;
   localparam logic [2:0] REG_MAXIMUM_CURRENT = 3'd3;
   localparam logic [2:0] REG_I2T_RATING      = 3'd4;

   // Trip modes.
   localparam logic [1:0] TRIP_NONE = 2'd0;
   localparam logic [1:0] TRIP_OC   = 2'd1;
   localparam logic [1:0] TRIP_VOLT = 2'd2;

   // Divider operand widths.
   localparam int VDIV_W = 23;
   localparam int VREF_W = 12;
   localparam int IDIV_W = 30;
   localparam int IDEN_W = 18;

   // Fixed-point gains: 1536 for voltage, 153600 and 61440 for current, 37 for the divisor.
   localparam logic [IDIV_W-1:0] I_VOLT_GAIN = 30'd153600;
   localparam logic [IDIV_W-1:0] I_CUR_GAIN  = 30'd61440;
   localparam logic [IDEN_W-1:0] I_DEN_GAIN  = 18'd37;
   localparam logic [8:0]        OFF_LOAD_Q8 = 9'd33;

   typedef struct packed {
      logic [7:0] max_voltage;
      logic [7:0] min_voltage;
      logic [7:0] nominal_current;
      logic [7:0] maximum_current;
      logic [7:0] i2t_rating;
   } cfg_type;

   // A prepared tick waiting for the divider.
   typedef struct packed {
      logic [VDIV_W-1:0] vdiv;
      logic [VREF_W-1:0] vref;
      logic [IDIV_W-1:0] imag;
      logic [IDEN_W-1:0] iden;
      logic              ineg;
      logic              vref_zero;
      logic [7:0]        cmd;
      logic [7:0]        hold;
   } prep_type;

endpackage

[rtl/lsp_if.sv]
// Channel interfaces for ticks in and results out.
// No dependencies.
interface lsp_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] volt_sample;
   logic [11:0] current_sample;
   logic [11:0] vref_sample;
   logic [7:0]  command_bits;
   logic [7:0]  diag_hold_bits;

   modport source (output valid, volt_sample, current_sample, vref_sample, command_bits,
                   diag_hold_bits, input ready);
   modport sink (input valid, volt_sample, current_sample, vref_sample, command_bits,
                 diag_hold_bits, output ready);
endinterface

interface lsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  relay_drive;
   logic        measure_valid;
   logic [7:0]  current_whole;
   logic [6:0]  current_hundredths;
   logic [7:0]  voltage_tenths;
   logic [2:0]  warning_flags;
   logic [17:0] fault_code_bits;
   logic [7:0]  locked_loads;

   modport source (output valid, relay_drive, measure_valid, current_whole,
                   current_hundredths, voltage_tenths, warning_flags, fault_code_bits,
                   locked_loads, input ready);
   modport sink (input valid, relay_drive, measure_valid, current_whole,
                 current_hundredths, voltage_tenths, warning_flags, fault_code_bits,
                 locked_loads, output ready);
endinterface

[rtl/lsp_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// No dependencies.
module lsp_div #(
   parameter int DW = 30,
   parameter int SW = 18
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [SW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [SW-1:0] dsr_ff, dsr_in;
   logic [SW:0]   trial;

   // One trial subtraction per cycle; dividend bits leave at the top of quo_ff.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = SW'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[SW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

[rtl/lsp_front.sv]
// Front end: accepts ticks, prepares divider operands and queues them.
// Depends on lsp_pkg and lsp_req_if.
module lsp_front (
   input  logic               clock,
   input  logic               reset,
   lsp_req_if.sink            req_port,
   input  logic               q_pop,
   output logic               q_valid,
   output lsp_pkg::prep_type  q_data
);
   lsp_pkg::prep_type         mem_ff [2];
   lsp_pkg::prep_type         prep;
   logic                      wr_ptr_ff, wr_ptr_in;
   logic                      rd_ptr_ff, rd_ptr_in;
   logic [1:0]                count_ff, count_in;
   logic                      push;
   logic [lsp_pkg::IDIV_W-1:0] pos, neg;

   // Operand preparation: scaled numerators, divisor and sign of the current.
   always_comb begin
      pos            = lsp_pkg::IDIV_W'(req_port.volt_sample) * lsp_pkg::I_VOLT_GAIN;
      neg            = lsp_pkg::IDIV_W'(req_port.current_sample) * lsp_pkg::I_CUR_GAIN;
      prep.vdiv      = {1'b0, req_port.volt_sample, 10'b0}
                       + {2'b0, req_port.volt_sample, 9'b0};
      prep.vref      = req_port.vref_sample;
      prep.ineg      = pos < neg;
      prep.imag      = prep.ineg ? (neg - pos) : (pos - neg);
      prep.iden      = lsp_pkg::IDEN_W'(req_port.vref_sample) * lsp_pkg::I_DEN_GAIN;
      prep.vref_zero = req_port.vref_sample == '0;
      prep.cmd       = req_port.command_bits;
      prep.hold      = req_port.diag_hold_bits;
   end

   // Two-entry queue between front and back.
   assign req_port.ready = count_ff != 2'd2;
   assign push           = req_port.valid && req_port.ready;
   assign q_valid        = count_ff != 2'd0;
   assign q_data         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= prep;
      end
   end
endmodule

[rtl/lsp_back.sv]
// Back end: divisions, I2t accumulator, shedding, fault search and result register.
// Depends on lsp_pkg, lsp_rsp_if and lsp_div.
module lsp_back #(
   parameter int NUM_LOADS  = 8,
   parameter int HEAT_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  lsp_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  lsp_pkg::prep_type q_data,
   output logic              q_pop,
   lsp_rsp_if.source         rsp_port
);
   localparam int EW = (HEAT_WIDTH > 21) ? HEAT_WIDTH + 1 : 22;
   localparam int NL = NUM_LOADS;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_CUR  = 5'b00100,
      ST_SQR  = 5'b01000,
      ST_UPD  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic                        start, commit;
   logic                        vbusy, ibusy;
   logic [lsp_pkg::VDIV_W-1:0]  vq;
   logic [lsp_pkg::IDIV_W-1:0]  iq;

   logic              vref_zero_ff, ineg_ff;
   logic [NL-1:0]     cmd_ff, hold_ff;
   logic [31:0]       cur_ff, cur_in;
   logic [23:0]       v_ff, v_in;
   logic [20:0]       inc_ff, inc_in;

   // Architectural state.
   logic [1:0]            warm_ff, warm_in;
   logic [HEAT_WIDTH-1:0] heat_ff, heat_in;
   logic [1:0]            trip_ff, trip_in;
   logic [NL-1:0]         status_ff, status_in;
   logic [NL-1:0]         marks_ff, marks_in;
   logic [1:0]            strike_ff [NL];
   logic [1:0]            strike_in [NL];
   logic [NL-1:0]         lock_ff, lock_in;
   logic [2:0]            warn_ff, warn_in;
   logic [17:0]           fault_ff, fault_in;

   // Result register.
   logic        rsp_valid_ff;
   logic [7:0]  relay_ff, whole_ff, tenths_ff;
   logic [6:0]  hund_ff;
   logic        meas_ff;
   logic [7:0]  relay_in, whole_in, tenths_in;
   logic [6:0]  hund_in;

   // Shared work signals.
   logic [3:0]    off_cnt;
   logic [31:0]   q_signed;
   logic [33:0]   sq;
   logic [36:0]   sq5;
   logic          meas_valid, cur_le_nom, cur_le_max, uv, ov, found;
   logic [15:0]   nom_sq;
   logic [EW-1:0] heat_e, thr_e, rate_e, sum_e, heat_max_e;
   logic [NL-1:0] low, marks_nx;
   logic [14:0]   hund_prod;
   logic [27:0]   tenths_prod;

   lsp_div #(.DW(lsp_pkg::VDIV_W), .SW(lsp_pkg::VREF_W)) u_vdiv (
      .clock(clock), .reset(reset), .start(start), .dividend(q_data.vdiv),
      .divisor(q_data.vref), .busy(vbusy), .quotient(vq)
   );

   lsp_div #(.DW(lsp_pkg::IDIV_W), .SW(lsp_pkg::IDEN_W)) u_idiv (
      .clock(clock), .reset(reset), .start(start), .dividend(q_data.imag),
      .divisor(q_data.iden), .busy(ibusy), .quotient(iq)
   );

   assign start  = (state_ff == ST_IDLE) && q_valid;
   assign q_pop  = start;
   assign commit = (state_ff == ST_UPD) && (!rsp_valid_ff || rsp_port.ready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (q_valid) state_in = ST_DIV;
         ST_DIV:  if (!vbusy && !ibusy) state_in = ST_CUR;
         ST_CUR:  state_in = ST_SQR;
         ST_SQR:  state_in = ST_UPD;
         ST_UPD:  if (commit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Current and voltage in 1/256 units, with the off-load correction.
   always_comb begin
      off_cnt = '0;
      for (int n = 0; n < NL; n++) begin
         off_cnt = off_cnt + {3'b0, ~status_ff[n]};
      end
      q_signed = ineg_ff ? (32'd0 - {2'b0, iq}) : {2'b0, iq};
      if (vref_zero_ff) begin
         cur_in = 32'h7FFF_FFFF;
         v_in   = 24'hFF_FFFF;
      end else begin
         cur_in = q_signed - 32'(lsp_pkg::OFF_LOAD_Q8 * 9'(off_cnt));
         v_in   = {1'b0, vq};
      end
   end

   // Heat increment I*I*5/65536, only used while the current lies in (0, 255 A].
   always_comb begin
      sq     = cur_ff[16:0] * cur_ff[16:0];
      sq5    = {1'b0, sq, 2'b0} + {3'b0, sq};
      inc_in = sq5[36:16];
   end

   // Per-tick state update.
   always_comb begin
      meas_valid = warm_ff[1];
      warm_in    = meas_valid ? warm_ff : warm_ff + 2'd1;
      heat_max_e = EW'({HEAT_WIDTH{1'b1}});
      heat_e     = EW'(heat_ff);
      nom_sq     = cfg.nominal_current * cfg.nominal_current;
      thr_e      = EW'({nom_sq, 2'b0}) + EW'(nom_sq);
      rate_e     = EW'(cfg.i2t_rating * 18'd1000);
      cur_le_nom = $signed(cur_ff) <= $signed({16'b0, cfg.nominal_current, 8'b0});
      cur_le_max = $signed(cur_ff) <= $signed({16'b0, cfg.maximum_current, 8'b0});
      uv         = {8'b0, cfg.min_voltage, 8'b0} > v_ff;
      ov         = {8'b0, cfg.max_voltage, 8'b0} < v_ff;
      status_in  = status_ff;
      trip_in    = trip_ff;
      marks_in   = marks_ff;
      strike_in  = strike_ff;
      lock_in    = lock_ff;
      warn_in    = warn_ff;
      fault_in   = fault_ff;
      found      = 1'b0;
      low        = '0;
      sum_e      = '0;
      marks_nx   = marks_ff >> 1;

      if (trip_ff == lsp_pkg::TRIP_NONE) begin
         status_in = (status_ff & hold_ff) | (cmd_ff & ~hold_ff);
      end

      if (meas_valid) begin
         // Accumulator: cool, heat or trip.
         if (cur_le_nom) begin
            if (heat_e >= thr_e) begin
               heat_e = heat_e - thr_e;
            end else begin
               // Strike the highest load of the lowest run of search marks.
               if (!uv) begin
                  for (int n = 0; n < NL; n++) begin
                     if (!found && marks_ff[n] && !marks_nx[n]) begin
                        strike_in[n] = strike_ff[n] + 2'd1;
                        fault_in[n]  = 1'b1;
                        found        = 1'b1;
                     end
                  end
                  if (!found) begin
                     fault_in[7:0] = '0;
                  end
               end
               warn_in[0] = 1'b0;
               heat_e     = '0;
               marks_in   = '0;
               trip_in    = lsp_pkg::TRIP_NONE;
            end
         end else if (cur_le_max) begin
            sum_e      = heat_e + EW'(inc_ff);
            warn_in[0] = 1'b1;
            heat_e     = (sum_e > heat_max_e) ? heat_max_e : sum_e;
            if (rate_e <= heat_e) begin
               trip_in = lsp_pkg::TRIP_OC;
            end
         end else begin
            warn_in[0] = 1'b1;
            trip_in    = lsp_pkg::TRIP_OC;
         end

         // Under-voltage keeps only the first two loads.
         if (uv) begin
            warn_in[1] = 1'b1;
            trip_in    = lsp_pkg::TRIP_VOLT;
            status_in  = status_in & NL'(3);
            fault_in[8] = 1'b1;
         end else begin
            warn_in[1]  = 1'b0;
            fault_in[8] = 1'b0;
         end

         // Over-voltage sheds everything.
         if (ov) begin
            warn_in[2]  = 1'b1;
            fault_in[9] = 1'b1;
            trip_in     = lsp_pkg::TRIP_VOLT;
            status_in   = '0;
         end else begin
            warn_in[2]  = 1'b0;
            fault_in[9] = 1'b0;
         end

         // Search step: switch off loads up to and including the lowest one on.
         if (trip_in == lsp_pkg::TRIP_OC && status_in != '0) begin
            low       = status_in ^ (status_in - 1'b1);
            status_in = status_in & ~low;
            marks_in  = marks_in | low;
         end

         // Three strikes lock a load.
         for (int n = 0; n < NL; n++) begin
            if (strike_in[n] == 2'd3) begin
               lock_in[n]      = 1'b1;
               strike_in[n]    = 2'd0;
               fault_in[10+n]  = 1'b1;
            end else begin
               fault_in[10+n]  = 1'b0;
            end
         end
         status_in = status_in & ~lock_in;
      end
      heat_in = heat_e[HEAT_WIDTH-1:0];
   end

   // Reported measurement fields.
   always_comb begin
      hund_prod   = cur_ff[7:0] * 7'd100;
      tenths_prod = {v_ff, 3'b0} + {3'b0, v_ff, 1'b0};
      whole_in    = '0;
      hund_in     = '0;
      tenths_in   = '0;
      relay_in    = '0;
      if (meas_valid) begin
         relay_in = 8'(status_in);
         if (cur_ff[31]) begin
            whole_in = '0;
            hund_in  = '0;
         end else if (cur_ff[30:16] != '0) begin
            whole_in = 8'd255;
            hund_in  = 7'd99;
         end else begin
            whole_in = cur_ff[15:8];
            hund_in  = hund_prod[14:8];
         end
         tenths_in = (tenths_prod[27:16] != '0) ? 8'd255 : tenths_prod[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         warm_ff      <= '0;
         heat_ff      <= '0;
         trip_ff      <= lsp_pkg::TRIP_NONE;
         status_ff    <= '0;
         marks_ff     <= '0;
         lock_ff      <= '0;
         warn_ff      <= '0;
         fault_ff     <= '0;
         for (int n = 0; n < NL; n++) begin
            strike_ff[n] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            warm_ff      <= warm_in;
            heat_ff      <= heat_in;
            trip_ff      <= trip_in;
            status_ff    <= status_in;
            marks_ff     <= marks_in;
            lock_ff      <= lock_in;
            warn_ff      <= warn_in;
            fault_ff     <= fault_in;
            strike_ff    <= strike_in;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // Working registers of the current tick.
      if (start) begin
         vref_zero_ff <= q_data.vref_zero;
         ineg_ff      <= q_data.ineg;
         cmd_ff       <= q_data.cmd[NL-1:0];
         hold_ff      <= q_data.hold[NL-1:0];
      end
      if (state_ff == ST_CUR) begin
         cur_ff <= cur_in;
         v_ff   <= v_in;
      end
      if (state_ff == ST_SQR) begin
         inc_ff <= inc_in;
      end
      if (commit) begin
         relay_ff  <= relay_in;
         meas_ff   <= meas_valid;
         whole_ff  <= whole_in;
         hund_ff   <= hund_in;
         tenths_ff <= tenths_in;
      end
   end

   assign rsp_port.valid              = rsp_valid_ff;
   assign rsp_port.relay_drive        = relay_ff;
   assign rsp_port.measure_valid      = meas_ff;
   assign rsp_port.current_whole      = whole_ff;
   assign rsp_port.current_hundredths = hund_ff;
   assign rsp_port.voltage_tenths     = tenths_ff;
   assign rsp_port.warning_flags      = warn_ff;
   assign rsp_port.fault_code_bits    = fault_ff;
   assign rsp_port.locked_loads       = 8'(lock_ff);
endmodule

[rtl/load_switch_i2t_protector_top.sv]
// Top level of the load switch protector: configuration registers, front and back.
// Depends on lsp_pkg, lsp_if, lsp_front, lsp_back and the assertion macro header.
//
//   Channel    Direction  Handshake           Content
//   req_port   in         valid/ready         ADC samples, load commands, hold bits
//   rsp_port   out        valid/ready         relay drive, measurements, flags, faults
//   csr (APB)  in         psel/penable/pready five 8-bit limit registers
//
// A tick passes into the queue, then through the two serial dividers (the 30-bit current
// quotient takes longest), then through ST_CUR, ST_SQR and ST_UPD to finish and register.
// The front queue holds two ticks, so the source keeps sending while one is worked on.
// Reset is synchronous and clears all protection state; no clearing pass is needed.
// A waiting result holds the back end in its final update step, so the next tick's divisions wait.
`include "load_switch_i2t_protector_top_macros.svh"
module load_switch_i2t_protector_top #(
   parameter int NUM_LOADS  = 8,
   parameter int HEAT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   lsp_req_if.sink     req_port,
   lsp_rsp_if.source   rsp_port,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   lsp_pkg::cfg_type  cfg_ff, cfg_in;
   lsp_pkg::prep_type q_data;
   logic              q_valid, q_pop;
   logic              wr_en;

   // Register writes on the access phase.
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[4:2])
            lsp_pkg::REG_MAX_VOLTAGE:     cfg_in.max_voltage     = pwdata[7:0];
            lsp_pkg::REG_MIN_VOLTAGE:     cfg_in.min_voltage     = pwdata[7:0];
            lsp_pkg::REG_NOMINAL_CURRENT: cfg_in.nominal_current = pwdata[7:0];
            lsp_pkg::REG_MAXIMUM_CURRENT: cfg_in.maximum_current = pwdata[7:0];
            lsp_pkg::REG_I2T_RATING:      cfg_in.i2t_rating      = pwdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (paddr[4:2])
         lsp_pkg::REG_MAX_VOLTAGE:     prdata = {24'b0, cfg_ff.max_voltage};
         lsp_pkg::REG_MIN_VOLTAGE:     prdata = {24'b0, cfg_ff.min_voltage};
         lsp_pkg::REG_NOMINAL_CURRENT: prdata = {24'b0, cfg_ff.nominal_current};
         lsp_pkg::REG_MAXIMUM_CURRENT: prdata = {24'b0, cfg_ff.maximum_current};
         lsp_pkg::REG_I2T_RATING:      prdata = {24'b0, cfg_ff.i2t_rating};
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lsp_front u_front (
      .clock(clock), .reset(reset), .req_port(req_port),
      .q_pop(q_pop), .q_valid(q_valid), .q_data(q_data)
   );

   lsp_back #(.NUM_LOADS(NUM_LOADS), .HEAT_WIDTH(HEAT_WIDTH)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .q_valid(q_valid),
      .q_data(q_data), .q_pop(q_pop), .rsp_port(rsp_port)
   );

   // A locked load is never driven.
   `LSP_ASSERT_IMPL(a_lock_off, clock, reset, rsp_port.valid,
      (rsp_port.relay_drive & rsp_port.locked_loads) == 8'd0)
   // Over-voltage sheds every load.
   `LSP_ASSERT_IMPL(a_ov_shed, clock, reset, rsp_port.valid && rsp_port.warning_flags[2],
      rsp_port.relay_drive == 8'd0)
   // The over-voltage fault code follows its warning flag.
   `LSP_ASSERT_IMPL(a_ov_code, clock, reset, rsp_port.valid,
      rsp_port.fault_code_bits[9] == rsp_port.warning_flags[2])
   // Warm-up results carry no measurements.
   `LSP_ASSERT_IMPL(a_warmup, clock, reset, rsp_port.valid && !rsp_port.measure_valid,
      rsp_port.current_whole == 8'd0 && rsp_port.voltage_tenths == 8'd0)
   // The queue is only popped when it holds a tick.
   `LSP_ASSERT_IMPL(a_pop_ok, clock, reset, q_pop, q_valid)
endmodule
